// ===== hdl/lfurt_pkg.sv =====
package lfurt_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int COUNT_BITS = 16;
	localparam int STAMP_BITS = 32;
	localparam int IDX_BITS   = $clog2(ENTRIES);
	localparam int TAG_W      = 32;
	localparam int VCOUNT_W   = 16;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_TOUCH  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [STAMP_BITS-1:0] stamp_t;
	typedef logic [IDX_BITS-1:0]   idx_t;

	localparam count_t COUNT_MAX = '1;
	localparam count_t COUNT_ONE = count_t'(1);

	typedef struct packed {
		key_t   key;
		count_t count;
		stamp_t stamp;
	} row_t;

	typedef struct packed {
		logic start;
		logic step;
		logic vld;
		idx_t idx;
	} scan_ctl_t;

	typedef struct packed {
		logic   match_found;
		idx_t   match_idx;
		logic   add_new;
		logic   dropped;
		logic   remove_hit;
		logic   wr_en;
		idx_t   wr_idx;
		count_t wr_count;
		logic   victim_vld;
		key_t   victim_key;
		count_t victim_count;
	} scan_res_t;

endpackage

// ===== hdl/lfurt_ram.sv =====
module lfurt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/lfurt_scan.sv =====
module lfurt_scan import lfurt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  scan_ctl_t ctl,
	input  row_t      row,
	input  logic [1:0] op,
	input  key_t      key,
	input  stamp_t    move_cnt,
	output scan_res_t res
);

	logic   match_found_q, free_found_q, best_vld_q;
	idx_t   match_idx_q, free_idx_q, best_idx_q;
	count_t match_count_q, best_count_q;
	stamp_t best_stamp_q;
	key_t   best_key_q;

	logic   hit, eff_vld, inc, better;
	count_t eff_count;
	stamp_t eff_stamp;

	// per-slot view after this beat's update
	always_comb begin
		hit       = ctl.vld && (row.key == key);
		eff_vld   = ctl.vld && !(hit && (op == OP_REMOVE));
		inc       = hit && (op == OP_TOUCH) && (row.count != COUNT_MAX);
		eff_count = inc ? row.count + COUNT_ONE : row.count;
		eff_stamp = inc ? move_cnt : row.stamp;
		better    = eff_vld && (!best_vld_q || (eff_count < best_count_q) ||
			((eff_count == best_count_q) && (eff_stamp < best_stamp_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_vld_q    <= 1'b0;
		end else if (ctl.start) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			best_vld_q    <= 1'b0;
		end else if (ctl.step) begin
			if (hit) begin
				match_found_q <= 1'b1;
			end
			if (!ctl.vld) begin
				free_found_q <= 1'b1;
			end
			if (better) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (hit) begin
				match_idx_q   <= ctl.idx;
				match_count_q <= row.count;
			end
			if (!ctl.vld && !free_found_q) begin
				free_idx_q <= ctl.idx;
			end
			if (better) begin
				best_idx_q   <= ctl.idx;
				best_count_q <= eff_count;
				best_stamp_q <= eff_stamp;
				best_key_q   <= row.key;
			end
		end
	end

	logic add_try, touch_hit, new_wins;

	always_comb begin
		add_try   = (op == OP_ADD) && !match_found_q;
		touch_hit = (op == OP_TOUCH) && match_found_q && (match_count_q != COUNT_MAX);
		new_wins  = !best_vld_q || (COUNT_ONE < best_count_q) ||
			((best_count_q == COUNT_ONE) && ((move_cnt < best_stamp_q) ||
			((move_cnt == best_stamp_q) && (free_idx_q < best_idx_q))));

		res.match_found = match_found_q;
		res.match_idx   = match_idx_q;
		res.add_new     = add_try && free_found_q;
		res.dropped     = add_try && !free_found_q;
		res.remove_hit  = (op == OP_REMOVE) && match_found_q;
		res.wr_en       = res.add_new || touch_hit;
		res.wr_idx      = res.add_new ? free_idx_q : match_idx_q;
		res.wr_count    = res.add_new ? COUNT_ONE : match_count_q + COUNT_ONE;

		if (res.add_new && new_wins) begin
			res.victim_vld   = 1'b1;
			res.victim_key   = key;
			res.victim_count = COUNT_ONE;
		end else begin
			res.victim_vld   = best_vld_q;
			res.victim_key   = best_vld_q ? best_key_q : '0;
			res.victim_count = best_vld_q ? best_count_q : '0;
		end
	end

endmodule

// ===== hdl/lfu_replacement_tracker.sv =====
// LFU replacement tracker.
// Request channel (req_valid/req_ready) carries operation and key_tag:
// add, touch or remove of a key. Response channel (rsp_valid/rsp_ready)
// returns one beat per request: was_present, add_dropped and the current
// eviction victim (lowest count, earliest to reach it, lowest slot on ties).
// Each request is handled by one compare unit that walks the entry table,
// one slot per cycle, out of a registered-read RAM: accept, a scan of every
// slot, a drain state, then an update state that loads the response register.
// The block takes a new request only once the last has left its update
// state, req_ready high only while idle.
// The response register lets the next request be accepted while a
// response waits; that request holds in its update cycle until the
// pending beat is taken. Reset clears all valid bits, the move counter
// and the response valid; no clearing pass is needed.
module lfu_replacement_tracker import lfurt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        operation,
	input  logic [TAG_W-1:0]  key_tag,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              was_present,
	output logic              add_dropped,
	output logic              victim_valid,
	output logic [TAG_W-1:0]  victim_key,
	output logic [VCOUNT_W-1:0] victim_count
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0]   state_q;
	idx_t         cnt_q;
	logic         step_s1;
	idx_t         idx_s1;
	logic [ENTRIES-1:0] entry_valid_q;
	stamp_t       move_cnt_q;
	logic [1:0]   op_q;
	key_t         key_q;
	logic         rsp_valid_q;

	logic         accept, fin_go;
	scan_ctl_t    ctl;
	scan_res_t    res;
	row_t         rd_row, wr_row;
	logic [$bits(row_t)-1:0] rd_bits;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign fin_go    = (state_q == ST_FINAL) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;

	assign rd_row = row_t'(rd_bits);
	always_comb begin
		wr_row.key   = key_q;
		wr_row.count = res.wr_count;
		wr_row.stamp = move_cnt_q;
		ctl.start    = accept;
		ctl.step     = step_s1;
		ctl.vld      = entry_valid_q[idx_s1];
		ctl.idx      = idx_s1;
	end

	lfurt_ram #(
		.WIDTH($bits(row_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (fin_go && res.wr_en),
		.waddr (res.wr_idx),
		.wdata (wr_row),
		.raddr (cnt_q),
		.rdata (rd_bits)
	);

	lfurt_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.row      (rd_row),
		.op       (op_q),
		.key      (key_q),
		.move_cnt (move_cnt_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			step_s1       <= 1'b0;
			entry_valid_q <= '0;
			move_cnt_q    <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			step_s1 <= (state_q == ST_SCAN);
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + idx_t'(1);
					if (cnt_q == idx_t'(ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINAL;
				end
				ST_FINAL: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (res.wr_en) begin
							move_cnt_q <= move_cnt_q + stamp_t'(1);
						end
						if (res.add_new) begin
							entry_valid_q[res.wr_idx] <= 1'b1;
						end
						if (res.remove_hit) begin
							entry_valid_q[res.match_idx] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (accept) begin
			op_q  <= operation;
			key_q <= key_t'(key_tag);
		end
		if (fin_go) begin
			was_present  <= res.match_found;
			add_dropped  <= res.dropped;
			victim_valid <= res.victim_vld;
			victim_key   <= TAG_W'(res.victim_key);
			victim_count <= VCOUNT_W'(res.victim_count);
		end
	end

	a_add_fills_one: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go && res.add_new |=>
		$countones(entry_valid_q) == $countones($past(entry_valid_q)) + 1)
		else $error("add did not claim exactly one slot");

	a_victim_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (victim_valid == (|entry_valid_q)))
		else $error("victim_valid disagrees with table occupancy");

	a_victim_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((victim_count != '0) == victim_valid))
		else $error("victim_count inconsistent with victim_valid");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && add_dropped |-> (&entry_valid_q))
		else $error("add dropped while a slot was free");

	a_stamp_only_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!fin_go |=> $stable(move_cnt_q))
		else $error("move counter changed outside update cycle");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import lfurt_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam int QUIET_LIMIT = 1000;

	typedef struct {
		logic [1:0]       op;
		logic [TAG_W-1:0] key;
	} request_t;

	typedef struct {
		logic                was_present;
		logic                add_dropped;
		logic                victim_valid;
		logic [TAG_W-1:0]    victim_key;
		logic [VCOUNT_W-1:0] victim_count;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	logic [1:0]          operation = OP_ADD;
	logic [TAG_W-1:0]    key_tag = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic                was_present;
	logic                add_dropped;
	logic                victim_valid;
	logic [TAG_W-1:0]    victim_key;
	logic [VCOUNT_W-1:0] victim_count;

	request_t         ops_to_send[$];
	answer_t          answers_due[$];
	answer_t          got_answer;
	logic [TAG_W-1:0] key_pool[POOL_SIZE];
	int               send_idle = 0;
	int               rsp_stall = 0;
	int               errors = 0;
	int               quiet_cycles = 0;

	// tracker shadow
	logic   slot_used[ENTRIES];
	key_t   slot_key[ENTRIES];
	count_t slot_count[ENTRIES];
	stamp_t slot_stamp[ENTRIES];
	stamp_t moves = '0;

	lfu_replacement_tracker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.operation    (operation),
		.key_tag      (key_tag),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.was_present  (was_present),
		.add_dropped  (add_dropped),
		.victim_valid (victim_valid),
		.victim_key   (victim_key),
		.victim_count (victim_count)
	);

	always #10 clk = ~clk;

	task automatic track_op(input logic [1:0] op, input logic [TAG_W-1:0] tag);
		key_t    k;
		int      hit_slot;
		int      free_slot;
		int      low_slot;
		answer_t a;
		k = tag[KEY_BITS-1:0];
		hit_slot = -1;
		free_slot = -1;
		low_slot = -1;
		a.add_dropped = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_key[i] == k && hit_slot < 0)
				hit_slot = i;
		case (op)
			OP_ADD: begin
				if (hit_slot < 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (!slot_used[i] && free_slot < 0)
							free_slot = i;
					if (free_slot < 0) begin
						a.add_dropped = 1'b1;
					end else begin
						slot_used[free_slot] = 1'b1;
						slot_key[free_slot] = k;
						slot_count[free_slot] = COUNT_ONE;
						slot_stamp[free_slot] = moves;
						moves = moves + 1'b1;
					end
				end
			end
			OP_TOUCH: begin
				if (hit_slot >= 0 && slot_count[hit_slot] != COUNT_MAX) begin
					slot_count[hit_slot] = slot_count[hit_slot] + 1'b1;
					slot_stamp[hit_slot] = moves;
					moves = moves + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (hit_slot >= 0)
					slot_used[hit_slot] = 1'b0;
			end
			default: ;
		endcase
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot_used[i] && (low_slot < 0 || slot_count[i] < slot_count[low_slot] ||
					(slot_count[i] == slot_count[low_slot] &&
					slot_stamp[i] < slot_stamp[low_slot])))
				low_slot = i;
		end
		a.was_present = (hit_slot >= 0);
		a.victim_valid = (low_slot >= 0);
		a.victim_key = (low_slot >= 0) ? TAG_W'(slot_key[low_slot]) : '0;
		a.victim_count = (low_slot >= 0) ? VCOUNT_W'(slot_count[low_slot]) : '0;
		answers_due.push_back(a);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic push_op(input logic [1:0] op, input logic [TAG_W-1:0] key);
		request_t r;
		r.op = op;
		r.key = key;
		ops_to_send.push_back(r);
	endtask

	task automatic push_random(input int n);
		int r;
		logic [1:0] op;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 40)
				op = OP_ADD;
			else if (r < 75)
				op = OP_TOUCH;
			else if (r < 95)
				op = OP_REMOVE;
			else
				op = OP_UNUSED;
			if ($urandom_range(9) == 0)
				push_op(op, $urandom);
			else
				push_op(op, key_pool[$urandom_range(POOL_SIZE - 1)]);
		end
	endtask

	task automatic drain();
		while (ops_to_send.size() != 0 || req_valid || answers_due.size() != 0)
			@(negedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			operation <= OP_ADD;
			key_tag <= '0;
		end else if (!req_valid || req_ready) begin
			if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle) begin
				req_valid <= 1'b1;
				operation <= ops_to_send[0].op;
				key_tag <= ops_to_send[0].key;
				void'(ops_to_send.pop_front());
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= ($urandom_range(99) >= rsp_stall);
	end

	// response monitor; prediction on request accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual key %h count %h",
						$time, victim_key, victim_count);
					errors++;
				end else begin
					got_answer = answers_due.pop_front();
					check_field("was_present", 32'(got_answer.was_present),
						32'(was_present));
					check_field("add_dropped", 32'(got_answer.add_dropped),
						32'(add_dropped));
					check_field("victim_valid", 32'(got_answer.victim_valid),
						32'(victim_valid));
					check_field("victim_key", got_answer.victim_key, victim_key);
					check_field("victim_count", 32'(got_answer.victim_count),
						32'(victim_count));
				end
			end
			if (req_valid && req_ready)
				track_op(operation, key_tag);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			slot_count[i] = '0;
			slot_stamp[i] = '0;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table, unused code, duplicates, absent keys
		push_op(OP_TOUCH, key_pool[0]);
		push_op(OP_REMOVE, key_pool[1]);
		push_op(OP_UNUSED, key_pool[0]);
		push_op(OP_ADD, key_pool[0]);
		push_op(OP_ADD, key_pool[1]);
		push_op(OP_ADD, key_pool[0]);
		push_op(OP_TOUCH, key_pool[0]);
		push_op(OP_UNUSED, key_pool[1]);
		push_op(OP_REMOVE, key_pool[1]);
		push_op(OP_TOUCH, key_pool[1]);
		// fill, overflow, reuse of a freed slot
		for (int i = 2; i <= 16; i++)
			push_op(OP_ADD, key_pool[i]);
		push_op(OP_ADD, key_pool[17]);
		push_op(OP_REMOVE, key_pool[5]);
		push_op(OP_ADD, key_pool[17]);
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle = 0;  rsp_stall = 0;  end
				1: begin send_idle = 82; rsp_stall = 0;  end
				2: begin send_idle = 0;  rsp_stall = 82; end
				default: begin send_idle = 34; rsp_stall = 34; end
			endcase
			push_random(130);
			drain();
		end

		repeat (2 * ENTRIES + 8) @(negedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
